@@ hdl/lmps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmps_pkg
// Shared types and constants for the LED matrix PWM scanner.
// ----------------------------------------------------------------------------
package lmps_pkg;

  // Width of one stored pixel level.
  localparam int unsigned LEVEL_W = 8;

  // Operation codes carried on the input channel.
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

endpackage

@@ hdl/led_matrix_pwm_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner
// Column-multiplexed LED matrix driver with per-pixel PWM. Pixel levels sit
// in one small RAM per row, addressed by column, so one read gives a column.
// ----------------------------------------------------------------------------
// Pipeline: the level RAM read registers at the accepting edge, then the drive
//   latches load and out_valid rises when the read stage moves on, which it
//   does only while the output register is empty or being taken.
// Throughput: one word per cycle when not stalled; RAM read and latch overlap.
// Reset: phase and column clear, no column or row is driven, and a valid bit
//   per pixel makes the level store read as zero; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module led_matrix_pwm_scanner #(
  parameter int unsigned MATRIX_SIZE = 5,
  parameter int unsigned PWM_BITS    = 6
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_op,
  input  logic [$clog2(MATRIX_SIZE*MATRIX_SIZE)-1:0] in_pixel_index,
  input  logic [lmps_pkg::LEVEL_W-1:0]              in_pixel_value,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [MATRIX_SIZE-1:0]                    out_column_select_n,
  output logic [MATRIX_SIZE-1:0]                    out_row_drive
);

  localparam int unsigned IDX_W = $clog2(MATRIX_SIZE * MATRIX_SIZE);
  localparam int unsigned COL_W = $clog2(MATRIX_SIZE);
  localparam int unsigned LVL_W = lmps_pkg::LEVEL_W;

  // Front-end state, advanced as words are accepted.
  logic [PWM_BITS-1:0]    phase_r, phase_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [MATRIX_SIZE-1:0] lvl_vld_r [MATRIX_SIZE];

  // Read stage registers.
  logic                   p1_vld_r;
  logic                   p1_tick_r;
  logic                   p1_zero_r;
  logic [PWM_BITS-1:0]    p1_phase_r;
  logic [COL_W-1:0]       p1_col_r;
  logic [MATRIX_SIZE-1:0] p1_lvl_vld_r;

  // Drive latches, which are also the output register.
  logic                   out_vld_r, out_vld_nxt;
  logic [MATRIX_SIZE-1:0] row_r, row_nxt;
  logic [MATRIX_SIZE-1:0] cath_r, cath_nxt;

  logic                   accept;
  logic                   is_tick;
  logic                   p1_go;
  logic [COL_W-1:0]       rd_col;
  logic                   wr_en;
  logic [COL_W-1:0]       wr_col;
  logic [COL_W-1:0]       wr_row;
  logic [LVL_W-1:0]       lane_rdata [MATRIX_SIZE];

  // Handshake: the read stage moves on whenever the output register is free.
  assign p1_go    = p1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !p1_vld_r || p1_go;
  assign accept   = in_valid && in_ready;
  assign is_tick  = (lmps_pkg::op_t'(in_op) == lmps_pkg::OP_TICK);

  // Phase and column advance on ticks; at phase zero the next column is read.
  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    if (accept && is_tick) begin
      phase_nxt = phase_r + PWM_BITS'(1);
      if (phase_r == '0) begin
        col_nxt = (col_r == COL_W'(MATRIX_SIZE - 1)) ? '0 : col_r + COL_W'(1);
      end
    end
  end

  assign rd_col = col_nxt;

  // Split a pixel index into column and row; out-of-range writes are dropped.
  always_comb begin
    wr_col = '0;
    wr_row = '0;
    for (int c = 0; c < MATRIX_SIZE; c++) begin
      if (in_pixel_index >= IDX_W'(c * MATRIX_SIZE)) begin
        wr_col = COL_W'(c);
        wr_row = COL_W'(in_pixel_index - IDX_W'(c * MATRIX_SIZE));
      end
    end
  end

  assign wr_en = accept && !is_tick &&
                 ({1'b0, in_pixel_index} < (IDX_W + 1)'(MATRIX_SIZE * MATRIX_SIZE));

  // One level RAM per row, addressed by column.
  for (genvar r = 0; r < MATRIX_SIZE; r++) begin : g_lane
    lmps_ram #(
      .WIDTH (LVL_W),
      .DEPTH (MATRIX_SIZE)
    ) u_lane_ram (
      .clk   (clk),
      .we    (wr_en && (wr_row == COL_W'(r))),
      .waddr (wr_col),
      .wdata (in_pixel_value),
      .re    (accept),
      .raddr (rd_col),
      .rdata (lane_rdata[r])
    );
  end

  // Front-end registers, pixel valid bits and the read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      col_r    <= '0;
      p1_vld_r <= 1'b0;
      for (int c = 0; c < MATRIX_SIZE; c++) begin
        lvl_vld_r[c] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      if (wr_en) begin
        lvl_vld_r[wr_col][wr_row] <= 1'b1;
      end
      if (accept) begin
        p1_vld_r <= 1'b1;
      end else if (p1_go) begin
        p1_vld_r <= 1'b0;
      end
    end
  end

  // Read stage payload, captured alongside the RAM read.
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_tick_r    <= is_tick;
      p1_zero_r    <= (phase_r == '0);
      p1_phase_r   <= phase_r;
      p1_col_r     <= col_nxt;
      p1_lvl_vld_r <= lvl_vld_r[rd_col];
    end
  end

  // Ticks reload column and rows at phase zero, else rows at their level go off.
  always_comb begin
    row_nxt     = row_r;
    cath_nxt    = cath_r;
    out_vld_nxt = out_vld_r;
    if (p1_go) begin
      out_vld_nxt = 1'b1;
      if (p1_tick_r) begin
        if (p1_zero_r) begin
          for (int c = 0; c < MATRIX_SIZE; c++) begin
            cath_nxt[c] = (p1_col_r != COL_W'(c));
          end
          for (int r = 0; r < MATRIX_SIZE; r++) begin
            row_nxt[r] = p1_lvl_vld_r[r] && (lane_rdata[r] != '0);
          end
        end else begin
          for (int r = 0; r < MATRIX_SIZE; r++) begin
            if (!p1_lvl_vld_r[r] ||
                (LVL_W'(p1_phase_r) >= lane_rdata[r])) begin
              row_nxt[r] = 1'b0;
            end
          end
        end
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      row_r     <= '0;
      cath_r    <= '1;
    end else begin
      out_vld_r <= out_vld_nxt;
      row_r     <= row_nxt;
      cath_r    <= cath_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_column_select_n = cath_r;
  assign out_row_drive       = row_r;

  // At most one column cathode is ever driven low.
  a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(~cath_r))
    else $error("more than one column selected");

  // Rows are only lit while some column is selected.
  a_rows_need_column: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r != '0) |-> (cath_r != '1))
    else $error("rows lit with no column selected");

  // The input side stalls only behind a held read stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (p1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // Every accepted tick advances the phase by one.
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_tick) |=> (phase_r == $past(phase_r) + PWM_BITS'(1)))
    else $error("phase did not advance on a tick");

  // The drive latches change only when a word enters the output register.
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !p1_go |=> ($stable(row_r) && $stable(cath_r)))
    else $error("drive changed without a word");

endmodule

@@ hdl/lmps_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lmps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 5
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
